// ----- sv/adf_pkg.sv -----
// Package with the parse phases, character codes and scaling constants of the decimal parser.
package adf_pkg;

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC
    } t_phase;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int DEF_MAX_INT_DIGITS  = 8;
    localparam int DEF_MAX_FRAC_DIGITS = 6;

    localparam int          SCALE_DIGITS = 6;
    localparam int          SCALE_W      = 20;
    localparam int          CNT_W        = 4;
    localparam logic [3:0]  CNT_SAT      = 4'd15;
    localparam logic [19:0] SCALE        = 20'd1000000;
    localparam int          OUT_W        = 48;
    localparam logic [47:0] MAG_MAX      = 48'h7FFF_FFFF_FFFF;

    function automatic logic [SCALE_W-1:0] adf_pow10(input logic [2:0] n);
        logic [SCALE_W-1:0] p;
        case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage

// ----- sv/ascii_decimal_to_fixed.sv -----
// Top level of the ASCII decimal to fixed-point parser, one character per transfer.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_char_code[7:0], i_last_char
//   result    out        o_valid / i_stall   o_valid_res, o_value_millionths[47:0]
//
// One character is taken in every cycle that o_stall is low; the parse state register
// holds the running digits. A result passes from its last character through a capture
// stage, a scaling stage and the output register, which takes the saturated sum.
// Reset clears the parse state and all stage valid flags.
// A stalled output holds the whole pipeline, and the input is stalled only while the
// output register holds a result that is being stalled.
module ascii_decimal_to_fixed
    import adf_pkg::*;
#(
    parameter int MAX_INT_DIGITS  = DEF_MAX_INT_DIGITS,
    parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_char_code,
    input  logic                    i_last_char,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_valid_res,
    output logic signed [OUT_W-1:0] o_value_millionths
);

    localparam int IntAccW  = $clog2(10 ** MAX_INT_DIGITS);
    localparam int FracKeep = (MAX_FRAC_DIGITS < SCALE_DIGITS) ? MAX_FRAC_DIGITS : SCALE_DIGITS;
    localparam int FracAccW = $clog2(10 ** FracKeep);
    localparam int ProdW    = IntAccW + SCALE_W;
    localparam int MagW     = ProdW + 1;

    localparam logic [CNT_W-1:0] IntLimit  = CNT_W'(MAX_INT_DIGITS);
    localparam logic [CNT_W-1:0] FracLimit = CNT_W'(MAX_FRAC_DIGITS);
    localparam logic [CNT_W-1:0] KeepLimit = CNT_W'(FracKeep);
    localparam logic [CNT_W-1:0] ScaleCnt  = CNT_W'(SCALE_DIGITS);

    t_phase               r_phase, n_phase;
    logic                 r_neg, n_neg;
    logic [IntAccW-1:0]   r_int, n_int;
    logic [FracAccW-1:0]  r_frac, n_frac;
    logic [CNT_W-1:0]     r_int_cnt, n_int_cnt;
    logic [CNT_W-1:0]     r_frac_cnt, n_frac_cnt;
    logic                 r_err, n_err;

    logic                 r_s1_valid, r_s1_ok, r_s1_neg;
    logic [IntAccW-1:0]   r_s1_int;
    logic [FracAccW-1:0]  r_s1_frac;
    logic [CNT_W-1:0]     r_s1_fcnt;

    logic                 r_s2_valid, r_s2_ok, r_s2_neg;
    logic [ProdW-1:0]     r_s2_int;
    logic [SCALE_W-1:0]   r_s2_frac;

    logic                 r_out_valid, r_out_res;
    logic [OUT_W-1:0]     r_out_val;

    logic                 advance, accept, is_digit, ok;
    logic [3:0]           digit;
    logic [2:0]           scale_idx;
    logic [MagW-1:0]      mag;
    logic [63:0]          mag64;
    logic [OUT_W-1:0]     mag_sat, value;

    assign advance  = !r_out_valid || !i_stall;
    assign o_stall  = !advance;
    assign accept   = i_valid && advance;
    assign is_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign digit    = 4'(i_char_code - CHAR_ZERO);

    always_comb begin
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_int      = r_int;
        n_frac     = r_frac;
        n_int_cnt  = r_int_cnt;
        n_frac_cnt = r_frac_cnt;
        n_err      = r_err;
        if (r_phase == PH_START && i_char_code == CHAR_MINUS) begin
            n_neg   = 1'b1;
            n_phase = PH_INT;
        end else if ((r_phase == PH_START || r_phase == PH_INT) && is_digit) begin
            n_phase = PH_INT;
            if (r_int_cnt < IntLimit) begin
                n_int = IntAccW'(32'(r_int) * 32'd10 + 32'(digit));
            end else begin
                n_err = 1'b1;
            end
            if (r_int_cnt < CNT_SAT) begin
                n_int_cnt = r_int_cnt + 1'b1;
            end
        end else if ((r_phase == PH_START || r_phase == PH_INT) && i_char_code == CHAR_DOT) begin
            if (r_int_cnt == '0) begin
                n_err = 1'b1;
            end
            n_phase = PH_FRAC;
        end else if (r_phase == PH_FRAC && is_digit) begin
            if (r_frac_cnt < FracLimit) begin
                if (r_frac_cnt < KeepLimit) begin
                    n_frac = FracAccW'(32'(r_frac) * 32'd10 + 32'(digit));
                end
            end else begin
                n_err = 1'b1;
            end
            if (r_frac_cnt < CNT_SAT) begin
                n_frac_cnt = r_frac_cnt + 1'b1;
            end
        end else begin
            n_err = 1'b1;
        end
    end

    assign ok = !n_err && n_phase == PH_FRAC && n_int_cnt != '0 && n_int_cnt <= IntLimit
                && n_frac_cnt != '0 && n_frac_cnt <= FracLimit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_neg      <= 1'b0;
            r_int      <= '0;
            r_frac     <= '0;
            r_int_cnt  <= '0;
            r_frac_cnt <= '0;
            r_err      <= 1'b0;
        end else if (accept) begin
            if (i_last_char) begin
                r_phase    <= PH_START;
                r_neg      <= 1'b0;
                r_int      <= '0;
                r_frac     <= '0;
                r_int_cnt  <= '0;
                r_frac_cnt <= '0;
                r_err      <= 1'b0;
            end else begin
                r_phase    <= n_phase;
                r_neg      <= n_neg;
                r_int      <= n_int;
                r_frac     <= n_frac;
                r_int_cnt  <= n_int_cnt;
                r_frac_cnt <= n_frac_cnt;
                r_err      <= n_err;
            end
        end
    end

    assign scale_idx = (r_s1_fcnt >= ScaleCnt) ? 3'd0 : 3'(ScaleCnt - r_s1_fcnt);

    assign mag     = MagW'(r_s2_int) + MagW'(r_s2_frac);
    assign mag64   = 64'(mag);
    assign mag_sat = (mag64 > 64'(MAG_MAX)) ? MAG_MAX : OUT_W'(mag64);
    assign value   = !r_s2_ok ? '0 : (r_s2_neg ? (OUT_W'(0) - mag_sat) : mag_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= accept && i_last_char;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ok   <= ok;
            r_s1_neg  <= n_neg;
            r_s1_int  <= n_int;
            r_s1_frac <= n_frac;
            r_s1_fcnt <= n_frac_cnt;
            r_s2_ok   <= r_s1_ok;
            r_s2_neg  <= r_s1_neg;
            r_s2_int  <= ProdW'(r_s1_int) * ProdW'(SCALE);
            r_s2_frac <= SCALE_W'(SCALE_W'(r_s1_frac) * adf_pow10(scale_idx));
            r_out_res <= r_s2_ok;
            r_out_val <= value;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_valid_res        = r_out_res;
    assign o_value_millionths = signed'(r_out_val);

endmodule

// ----- sv/adf_checker.sv -----
// Port-level checker for the decimal parser, bound to the top level.
module adf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_valid_res,
    input logic [47:0] o_value_millionths
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Result transfer dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_valid_res) && $stable(o_value_millionths))
        else $error("Stalled result changed.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_value_millionths == 48'd0)
        else $error("Invalid result carries a non-zero value.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled without a stalled result.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid straight after reset.");

endmodule

bind ascii_decimal_to_fixed adf_checker u_adf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_valid_res        (o_valid_res),
    .o_value_millionths (o_value_millionths)
);
